FILE: rtl/smsd_pkg.sv
// Shared constants and types for the sliding median spike detector.
package smsd_pkg;

	localparam int BIN_COUNT_DEF  = 256;
	localparam int WINDOW_MAX_DEF = 256;

	localparam int SAMPLE_W    = 8;
	localparam int WLEN_W      = 9;
	localparam int TWICE_W     = 9;
	localparam int TOTAL_W     = 32;
	localparam int OUT_FIELD_W = 1 + TWICE_W + TOTAL_W;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

	// control part of the scan token that walks the cell row
	typedef struct packed {
		logic valid;
		logic clear;
		logic scan;
		logic found1;
		logic found2;
	} tok_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_LATCH,
		ST_LAUNCH,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

FILE: rtl/smsd_cell.sv
// One histogram bin: holds its count, adds it to the passing cumulative sum.
module smsd_cell #(
	parameter int BIN_COUNT  = smsd_pkg::BIN_COUNT_DEF,
	parameter int WINDOW_MAX = smsd_pkg::WINDOW_MAX_DEF,
	parameter int IDX        = 0,
	localparam int W_EFF     = (WINDOW_MAX < 511) ? WINDOW_MAX : 511,
	localparam int CW        = $clog2(W_EFF + 1),
	localparam int BW        = $clog2(BIN_COUNT)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  smsd_pkg::tok_ctl_t tok_in,
	input  logic [CW-1:0]      cum_in,
	input  logic [BW-1:0]      b1_in,
	input  logic [BW-1:0]      b2_in,
	input  logic [CW-1:0]      rank1,
	input  logic [CW-1:0]      rank2,
	input  logic [BW-1:0]      inc_bin,
	input  logic [BW-1:0]      dec_bin,
	output smsd_pkg::tok_ctl_t tok_out,
	output logic [CW-1:0]      cum_out,
	output logic [BW-1:0]      b1_out,
	output logic [BW-1:0]      b2_out
);

	localparam logic [BW-1:0] MY_BIN = BW'(IDX);

	logic [CW-1:0]      count_q;
	smsd_pkg::tok_ctl_t tok_q;
	logic [CW-1:0]      cum_q;
	logic [BW-1:0]      b1_q;
	logic [BW-1:0]      b2_q;

	logic [CW-1:0]      base;
	logic [CW-1:0]      sum;
	logic               hit1;
	logic               hit2;
	logic               dec;
	logic               inc;
	logic [CW-1:0]      count_d;
	smsd_pkg::tok_ctl_t tok_d;

	always_comb begin
		base    = tok_in.clear ? '0 : count_q;
		sum     = cum_in + base;
		hit1    = tok_in.scan && !tok_in.found1 && (sum >= rank1);
		hit2    = tok_in.scan && !tok_in.found2 && (sum >= rank2);
		dec     = tok_in.scan && (dec_bin == MY_BIN) && (base != '0);
		inc     = (inc_bin == MY_BIN);
		count_d = base - CW'(dec) + CW'(inc);
		tok_d        = tok_in;
		tok_d.found1 = tok_in.found1 | hit1;
		tok_d.found2 = tok_in.found2 | hit2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	always_ff @(posedge clk) begin
		cum_q <= sum;
		b1_q  <= hit1 ? MY_BIN : b1_in;
		b2_q  <= hit2 ? MY_BIN : b2_in;
		if (tok_in.valid) begin
			count_q <= count_d;
		end
	end

	assign tok_out = tok_q;
	assign cum_out = cum_q;
	assign b1_out  = b1_q;
	assign b2_out  = b2_q;

endmodule

FILE: rtl/smsd_ctrl.sv
// Sequencer: stream handshake, window bookkeeping, sample delay line, result.
module smsd_ctrl #(
	parameter int BIN_COUNT  = smsd_pkg::BIN_COUNT_DEF,
	parameter int WINDOW_MAX = smsd_pkg::WINDOW_MAX_DEF,
	localparam int W_EFF     = (WINDOW_MAX < 511) ? WINDOW_MAX : 511,
	localparam int CW        = $clog2(W_EFF + 1),
	localparam int BW        = $clog2(BIN_COUNT),
	localparam int PW        = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
	localparam int SW        = $clog2(WINDOW_MAX + 1) + 1,
	localparam int MW        = (BW + 1 > smsd_pkg::SAMPLE_W) ? BW + 1 : smsd_pkg::SAMPLE_W
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [smsd_pkg::SAMPLE_W-1:0]      s_tdata,
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [smsd_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input  logic                               cfg_wr_en,
	input  logic [smsd_pkg::WLEN_W-1:0]        cfg_wr_data,
	output smsd_pkg::tok_ctl_t                 launch_tok,
	output logic [CW-1:0]                      rank1,
	output logic [CW-1:0]                      rank2,
	output logic [BW-1:0]                      inc_bin,
	output logic [BW-1:0]                      dec_bin,
	input  smsd_pkg::tok_ctl_t                 end_tok,
	input  logic [BW-1:0]                      end_b1,
	input  logic [BW-1:0]                      end_b2
);

	smsd_pkg::state_t state_q;
	smsd_pkg::state_t state_d;

	logic [smsd_pkg::WLEN_W-1:0]   window_q;
	logic [CW-1:0]                 fill_q;
	logic [PW-1:0]                 ptr_q;
	logic [smsd_pkg::TOTAL_W-1:0]  alert_cnt_q;
	logic                          pending_clear_q;

	logic [smsd_pkg::SAMPLE_W-1:0] sample_q;
	logic [BW-1:0]                 inc_bin_q;
	logic [BW-1:0]                 dec_bin_q;
	logic [CW-1:0]                 rank1_q;
	logic [CW-1:0]                 rank2_q;
	logic                          scan_q;
	logic                          clear_q;
	logic [PW-1:0]                 slot_q;
	logic [PW-1:0]                 wr_ptr_q;
	logic [smsd_pkg::SAMPLE_W-1:0] rd_data_q;
	logic [BW:0]                   twice_q;

	logic [smsd_pkg::SAMPLE_W-1:0] hist_mem [WINDOW_MAX];

	logic                          out_valid_q;
	logic                          out_alert_q;
	logic [smsd_pkg::TWICE_W-1:0]  out_twice_q;
	logic [smsd_pkg::TOTAL_W-1:0]  out_total_q;

	logic                          accept;
	logic                          load_out;
	logic [smsd_pkg::WLEN_W-1:0]   w0;
	logic [CW-1:0]                 w_act;
	logic                          clr;
	logic [CW-1:0]                 fill_eff;
	logic [PW-1:0]                 ptr_eff;
	logic [PW-1:0]                 ptr_next;
	logic                          scan_d;
	logic [CW-1:0]                 half;
	logic [CW-1:0]                 rank1_d;
	logic [CW-1:0]                 rank2_d;
	logic [SW-1:0]                 ptr_ext;
	logic [SW-1:0]                 w_ext;
	logic [PW-1:0]                 slot_d;
	logic [BW-1:0]                 bin_d;
	logic [BW:0]                   twice_sum;
	logic                          alert_d;
	logic [smsd_pkg::TOTAL_W-1:0]  total_d;

	always_comb begin
		w0       = (window_q == '0) ? smsd_pkg::WLEN_W'(1) : window_q;
		w_act    = CW'((int'(w0) > WINDOW_MAX) ? WINDOW_MAX : int'(w0));
		clr      = s_tuser | pending_clear_q;
		fill_eff = clr ? '0 : fill_q;
		ptr_eff  = clr ? '0 : ptr_q;
		ptr_next = (int'(ptr_eff) == WINDOW_MAX - 1) ? '0 : ptr_eff + PW'(1);
		scan_d   = (fill_eff >= w_act);
		half     = w_act >> 1;
		rank2_d  = half + CW'(1);
		rank1_d  = w_act[0] ? rank2_d : half;
		ptr_ext  = SW'(ptr_eff);
		w_ext    = SW'(w_act);
		slot_d   = (ptr_ext >= w_ext) ? PW'(ptr_ext - w_ext)
		                              : PW'(ptr_ext + SW'(WINDOW_MAX) - w_ext);
		bin_d    = (int'(s_tdata) > BIN_COUNT - 1) ? BW'(BIN_COUNT - 1) : BW'(s_tdata);
		twice_sum = (BW + 1)'(end_b1) + (BW + 1)'(end_b2);
		alert_d  = (MW'(sample_q) >= MW'(twice_q));
		total_d  = (alert_d && (alert_cnt_q != '1)) ? alert_cnt_q + 1'b1 : alert_cnt_q;
	end

	// next state and handshake
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		accept   = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			smsd_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					accept  = 1'b1;
					state_d = smsd_pkg::ST_FETCH;
				end
			end
			smsd_pkg::ST_FETCH:  state_d = smsd_pkg::ST_LATCH;
			smsd_pkg::ST_LATCH:  state_d = smsd_pkg::ST_LAUNCH;
			smsd_pkg::ST_LAUNCH: state_d = smsd_pkg::ST_SCAN;
			smsd_pkg::ST_SCAN: begin
				if (end_tok.valid) begin
					state_d = scan_q ? smsd_pkg::ST_DONE : smsd_pkg::ST_IDLE;
				end
			end
			smsd_pkg::ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = smsd_pkg::ST_IDLE;
				end
			end
			default: state_d = smsd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smsd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q        <= smsd_pkg::WLEN_W'(1);
			fill_q          <= '0;
			ptr_q           <= '0;
			alert_cnt_q     <= '0;
			pending_clear_q <= 1'b1;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				window_q        <= cfg_wr_data;
				fill_q          <= '0;
				ptr_q           <= '0;
				alert_cnt_q     <= '0;
				pending_clear_q <= 1'b1;
			end else if (accept) begin
				pending_clear_q <= 1'b0;
				fill_q          <= scan_d ? fill_eff : fill_eff + CW'(1);
				ptr_q           <= ptr_next;
				if (clr) begin
					alert_cnt_q <= '0;
				end
			end else if (load_out) begin
				alert_cnt_q <= total_d;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q  <= s_tdata;
			inc_bin_q <= bin_d;
			rank1_q   <= rank1_d;
			rank2_q   <= rank2_d;
			scan_q    <= scan_d;
			clear_q   <= clr;
			slot_q    <= slot_d;
			wr_ptr_q  <= ptr_eff;
		end
		rd_data_q <= hist_mem[slot_q];
		if (state_q == smsd_pkg::ST_LATCH) begin
			dec_bin_q          <= BW'(rd_data_q);
			hist_mem[wr_ptr_q] <= smsd_pkg::SAMPLE_W'(inc_bin_q);
		end
		if (state_q == smsd_pkg::ST_SCAN && end_tok.valid) begin
			twice_q <= twice_sum;
		end
		if (load_out) begin
			out_alert_q <= alert_d;
			out_twice_q <= smsd_pkg::TWICE_W'(twice_q);
			out_total_q <= total_d;
		end
	end

	always_comb begin
		launch_tok        = '0;
		launch_tok.valid  = (state_q == smsd_pkg::ST_LAUNCH);
		launch_tok.clear  = clear_q;
		launch_tok.scan   = scan_q;
	end

	assign rank1    = rank1_q;
	assign rank2    = rank2_q;
	assign inc_bin  = inc_bin_q;
	assign dec_bin  = dec_bin_q;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{smsd_pkg::OUT_PAD_W{1'b0}}, out_total_q, out_twice_q, out_alert_q};

endmodule

FILE: rtl/sliding_median_spike_detector.sv
// Sliding median spike detector: sequencer plus a row of BIN_COUNT histogram cells.
// Path: a request goes through FETCH, LATCH, LAUNCH, the scan token's walk along the
//   cell row (one bin per cycle) and DONE, which sets m_tvalid; the fill phase gives no result.
// Flow: a new request is taken only in IDLE; a result may wait in the output register
//   while the next request is worked on, which then stalls until it drains.
// Reset: control clears at once; the histogram is cleared by the first request's pass.
module sliding_median_spike_detector #(
	parameter int BIN_COUNT  = smsd_pkg::BIN_COUNT_DEF,
	parameter int WINDOW_MAX = smsd_pkg::WINDOW_MAX_DEF,
	localparam int W_EFF     = (WINDOW_MAX < 511) ? WINDOW_MAX : 511,
	localparam int CW        = $clog2(W_EFF + 1),
	localparam int BW        = $clog2(BIN_COUNT)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [smsd_pkg::SAMPLE_W-1:0]    s_tdata,   // [7:0] sample_value
	input  logic                             s_tuser,   // start_sequence
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [smsd_pkg::OUT_TDATA_W-1:0] m_tdata,   // alert, twice_median, alert_total
	input  logic                             cfg_wr_en,
	input  logic [smsd_pkg::WLEN_W-1:0]      cfg_wr_data
);

	smsd_pkg::tok_ctl_t tok_link [BIN_COUNT + 1];
	logic [CW-1:0]      cum_link [BIN_COUNT + 1];
	logic [BW-1:0]      b1_link  [BIN_COUNT + 1];
	logic [BW-1:0]      b2_link  [BIN_COUNT + 1];

	logic [CW-1:0] rank1;
	logic [CW-1:0] rank2;
	logic [BW-1:0] inc_bin;
	logic [BW-1:0] dec_bin;

	smsd_ctrl #(
		.BIN_COUNT  (BIN_COUNT),
		.WINDOW_MAX (WINDOW_MAX)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.launch_tok  (tok_link[0]),
		.rank1       (rank1),
		.rank2       (rank2),
		.inc_bin     (inc_bin),
		.dec_bin     (dec_bin),
		.end_tok     (tok_link[BIN_COUNT]),
		.end_b1      (b1_link[BIN_COUNT]),
		.end_b2      (b2_link[BIN_COUNT])
	);

	// token starts with an empty sum; unmatched ranks fall to the top bin
	assign cum_link[0] = '0;
	assign b1_link[0]  = BW'(BIN_COUNT - 1);
	assign b2_link[0]  = BW'(BIN_COUNT - 1);

	for (genvar j = 0; j < BIN_COUNT; j++) begin : g_cell
		smsd_cell #(
			.BIN_COUNT  (BIN_COUNT),
			.WINDOW_MAX (WINDOW_MAX),
			.IDX        (j)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok_link[j]),
			.cum_in  (cum_link[j]),
			.b1_in   (b1_link[j]),
			.b2_in   (b2_link[j]),
			.rank1   (rank1),
			.rank2   (rank2),
			.inc_bin (inc_bin),
			.dec_bin (dec_bin),
			.tok_out (tok_link[j + 1]),
			.cum_out (cum_link[j + 1]),
			.b1_out  (b1_link[j + 1]),
			.b2_out  (b2_link[j + 1])
		);
	end

endmodule
